// ===== src/pcd_pkg.sv =====
// Package for the PNG chunk deframer: phase type, output phase codes,
// signature bytes, chunk type words and the counter/offset widths.
// No dependencies.
package pcd_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int OFFSET_BITS = 32;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(8);

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_TYPE = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRC  = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    localparam logic [2:0] PHASE_CODE_SIG  = 3'd0;
    localparam logic [2:0] PHASE_CODE_LEN  = 3'd1;
    localparam logic [2:0] PHASE_CODE_TYPE = 3'd2;
    localparam logic [2:0] PHASE_CODE_DATA = 3'd3;
    localparam logic [2:0] PHASE_CODE_CRC  = 3'd4;
    localparam logic [2:0] PHASE_CODE_DONE = 3'd5;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_IHDR  = 2'd1;
    localparam logic [1:0] KIND_IDAT  = 2'd2;
    localparam logic [1:0] KIND_IEND  = 2'd3;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] classify(input logic [31:0] t);
        logic [1:0] k;
        if (t == TYPE_IHDR) begin
            k = KIND_IHDR;
        end else if (t == TYPE_IDAT) begin
            k = KIND_IDAT;
        end else if (t == TYPE_IEND) begin
            k = KIND_IEND;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] c;
        case (ph)
            PH_SIG:  c = PHASE_CODE_SIG;
            PH_LEN:  c = PHASE_CODE_LEN;
            PH_TYPE: c = PHASE_CODE_TYPE;
            PH_DATA: c = PHASE_CODE_DATA;
            PH_CRC:  c = PHASE_CODE_CRC;
            PH_DONE: c = PHASE_CODE_DONE;
            default: c = PHASE_CODE_SIG;
        endcase
        return c;
    endfunction

endpackage

// ===== src/png_chunk_deframer_unit.sv =====
// PNG chunk deframer top level: byte-wide parser state and result register.
// Depends on pcd_pkg.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_ready   i_data_byte (one file byte per word)
//   result   out        o_valid / i_ready   o_phase .. o_end_seen (one per word)
//
// Each accepted byte updates the parser state; its result is
// visible the next cycle. Throughput is one byte per cycle, limited only by
// the single result register: a new byte is taken whenever that register is
// empty or is being read in the same cycle. Reset (synchronous) returns to
// the signature phase with the chunk offset at eight and empties the result.
module png_chunk_deframer_unit
    import pcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_phase,
    output logic        o_signature_bad,
    output logic [31:0] o_length_word,
    output logic [1:0]  o_chunk_kind,
    output logic        o_type_complete,
    output logic [31:0] o_crc_value,
    output logic        o_crc_complete,
    output logic [15:0] o_idat_count,
    output logic [31:0] o_chunk_offset,
    output logic        o_end_seen
);

    t_phase                 r_phase,      n_phase;
    logic [2:0]             r_index,      n_index;
    logic                   r_sig_bad,    n_sig_bad;
    logic [31:0]            r_length,     n_length;
    logic [31:0]            r_remaining,  n_remaining;
    logic [31:0]            r_type,       n_type;
    logic [31:0]            r_crc,        n_crc;
    logic [COUNT_BITS-1:0]  r_idat,       n_idat;
    logic [OFFSET_BITS-1:0] r_position,   n_position;
    logic [OFFSET_BITS-1:0] r_start,      n_start;
    logic [1:0]             r_kind,       n_kind;
    logic                   r_type_pulse, n_type_pulse;
    logic                   r_crc_pulse,  n_crc_pulse;
    logic                   r_valid;
    logic                   w_accept;
    logic [31:0]            w_length_shift;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_length_shift = {r_length[23:0], i_data_byte};

    always_comb begin
        n_phase      = r_phase;
        n_index      = r_index;
        n_sig_bad    = r_sig_bad;
        n_length     = r_length;
        n_remaining  = r_remaining;
        n_type       = r_type;
        n_crc        = r_crc;
        n_idat       = r_idat;
        n_position   = r_position;
        n_start      = r_start;
        n_type_pulse = 1'b0;
        n_crc_pulse  = 1'b0;

        if (r_phase != PH_DONE) begin
            n_position = r_position + OFFSET_BITS'(1);
        end

        case (r_phase)
            PH_SIG: begin
                if (i_data_byte != sig_byte(r_index)) begin
                    n_sig_bad = 1'b1;
                end
                n_index = r_index + 3'd1;
                if (r_index == 3'd7) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (r_index == 3'd0) begin
                    // first length byte opens a new chunk: clear the words
                    n_start  = r_position;
                    n_length = {24'd0, i_data_byte};
                    n_type   = 32'd0;
                    n_crc    = 32'd0;
                end else begin
                    n_length = w_length_shift;
                end
                n_index = r_index + 3'd1;
                if (r_index == 3'd3) begin
                    n_index = 3'd0;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = {r_type[23:0], i_data_byte};
                n_index = r_index + 3'd1;
                if (r_index == 3'd3) begin
                    n_index      = 3'd0;
                    n_type_pulse = 1'b1;
                    n_remaining  = r_length;
                    n_phase      = (r_length == 32'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                n_remaining = r_remaining - 32'd1;
                if (r_remaining == 32'd1) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_crc   = {r_crc[23:0], i_data_byte};
                n_index = r_index + 3'd1;
                if (r_index == 3'd3) begin
                    n_index     = 3'd0;
                    n_crc_pulse = 1'b1;
                    if (r_kind == KIND_IDAT && r_idat != COUNT_MAX) begin
                        n_idat = r_idat + COUNT_BITS'(1);
                    end
                    n_phase = (r_kind == KIND_IEND) ? PH_DONE : PH_LEN;
                end
            end
            PH_DONE: begin
                // hold everything; later bytes are dropped
            end
            default: begin
                n_phase = PH_SIG;
            end
        endcase

        n_kind = classify(n_type);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIG;
            r_index      <= 3'd0;
            r_sig_bad    <= 1'b0;
            r_length     <= 32'd0;
            r_remaining  <= 32'd0;
            r_type       <= 32'd0;
            r_crc        <= 32'd0;
            r_idat       <= '0;
            r_position   <= '0;
            r_start      <= OFFSET_RESET;
            r_kind       <= KIND_OTHER;
            r_type_pulse <= 1'b0;
            r_crc_pulse  <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase      <= n_phase;
                r_index      <= n_index;
                r_sig_bad    <= n_sig_bad;
                r_length     <= n_length;
                r_remaining  <= n_remaining;
                r_type       <= n_type;
                r_crc        <= n_crc;
                r_idat       <= n_idat;
                r_position   <= n_position;
                r_start      <= n_start;
                r_kind       <= n_kind;
                r_type_pulse <= n_type_pulse;
                r_crc_pulse  <= n_crc_pulse;
                r_valid      <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // State only advances when a word is taken, so it is the held result.
    assign o_valid         = r_valid;
    assign o_phase         = phase_code(r_phase);
    assign o_signature_bad = r_sig_bad;
    assign o_length_word   = r_length;
    assign o_chunk_kind    = r_kind;
    assign o_type_complete = r_type_pulse;
    assign o_crc_value     = r_crc;
    assign o_crc_complete  = r_crc_pulse;
    assign o_idat_count    = 16'(r_idat);
    assign o_chunk_offset  = 32'(r_start);
    assign o_end_seen      = (r_phase == PH_DONE);

endmodule
